// ===== sv/afd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and state codes of the allele frequency distance unit
package afd_pkg;

  localparam int FREQ_W        = 17;
  localparam int USER_W        = 2;
  localparam int SQ_W          = 38;
  localparam int CU_W          = 54;
  localparam int DIST_W        = 19;
  localparam int CUOUT_W       = 38;
  localparam int CNT_W         = 6;
  localparam int NUM_SQ        = 6;
  localparam int NUM_CU        = 3;
  localparam int MAX_SNPS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic valid;
    logic clear;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_ACC   = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_OUT   = 4'b1000
  } afd_state_t;

endpackage

// ===== sv/allele_frequency_distance_unit.sv =====
`timescale 1ns / 1ps
// allele frequency distance unit: six difference lanes, shared root unit, result stage
// throughput: one snp per cycle within a set; the cycle after the closing snp the input stalls
// sequence: after the closing snp the lanes drain, then the six roots are taken in turn on the
//   shared root unit before out_valid; the input reopens the cycle after the result transfer
// reset: rst (synchronous, active high) clears all sums, the snp count and the sequencer;
//   no clearing pass is needed
module allele_frequency_distance_unit #(
  parameter int MAX_SNPS  = afd_pkg::MAX_SNPS_DEF,
  parameter int FRAC_BITS = afd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [afd_pkg::FREQ_W-1:0]  freq_a,
  input  logic [afd_pkg::FREQ_W-1:0]  freq_b,
  input  logic [afd_pkg::FREQ_W-1:0]  freq_c,
  input  logic [afd_pkg::USER_W-1:0]  user_derived,
  input  logic                        last_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [afd_pkg::DIST_W-1:0]  dist_user_a,
  output logic [afd_pkg::DIST_W-1:0]  dist_user_b,
  output logic [afd_pkg::DIST_W-1:0]  dist_user_c,
  output logic [afd_pkg::CUOUT_W-1:0] cube_sum_a,
  output logic [afd_pkg::CUOUT_W-1:0] cube_sum_b,
  output logic [afd_pkg::CUOUT_W-1:0] cube_sum_c,
  output logic [afd_pkg::DIST_W-1:0]  dist_a_b,
  output logic [afd_pkg::DIST_W-1:0]  dist_a_c,
  output logic [afd_pkg::DIST_W-1:0]  dist_b_c
);
  import afd_pkg::*;

  // lane width covers both the raw frequencies and the scaled user count
  localparam int DW = ((FRAC_BITS + 1) > FREQ_W) ? (FRAC_BITS + 1) : FREQ_W;
  localparam logic [CNT_W-1:0]   CNT_ONES   = '1;
  localparam logic [CUOUT_W-1:0] CUOUT_ONES = '1;

  afd_state_t state;
  lane_ctl_t  ctl;
  logic       accept;
  logic       last_eff;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [DW-1:0]    fu;
  logic [DW-1:0]    lx [NUM_SQ];
  logic [DW-1:0]    ly [NUM_SQ];
  logic [NUM_SQ-1:0] lane_busy;
  logic [SQ_W-1:0]  sq_sums [NUM_SQ];
  logic [CU_W-1:0]  cu_sums [NUM_SQ];
  logic [2:0]       idx;
  logic             root_go;
  logic             root_done;
  logic [DIST_W-1:0] root_val;
  logic [DIST_W-1:0] dist_q [NUM_SQ];
  logic [CUOUT_W-1:0] cube_q [NUM_CU];
  logic [CUOUT_W-1:0] cube_r [NUM_CU];

  // input side handshake: snps flow only while accumulating
  assign in_stall  = (state != ST_ACC);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);

  // snp count saturates; a full set closes even without the last mark
  assign cnt_inc  = (cnt != CNT_ONES) ? cnt + 1'b1 : cnt;
  assign last_eff = last_item || (32'(cnt_inc) >= MAX_SNPS);

  // user frequency is the derived count halved
  assign fu = DW'(user_derived) << (FRAC_BITS - 1);

  always_comb begin
    lx[0] = fu;            ly[0] = DW'(freq_a);
    lx[1] = fu;            ly[1] = DW'(freq_b);
    lx[2] = fu;            ly[2] = DW'(freq_c);
    lx[3] = DW'(freq_a);   ly[3] = DW'(freq_b);
    lx[4] = DW'(freq_a);   ly[4] = DW'(freq_c);
    lx[5] = DW'(freq_b);   ly[5] = DW'(freq_c);
  end

  // sums clear once the result transfer completes
  assign ctl.valid = accept;
  assign ctl.clear = (state == ST_OUT) && !out_stall;

  genvar g;
  generate
    for (g = 0; g < NUM_SQ; g++) begin : g_lane
      afd_lane #(
        .DW       (DW),
        .HAS_CUBE (g < NUM_CU)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .x      (lx[g]),
        .y      (ly[g]),
        .busy   (lane_busy[g]),
        .sq_sum (sq_sums[g]),
        .cu_sum (cu_sums[g])
      );
    end
  endgenerate

  // cube sums from 3*frac down to 2*frac fraction bits: round half up, then clamp to the output width
  always_comb begin
    logic [CU_W:0] rnd;
    logic [CU_W:0] shr;
    for (int i = 0; i < NUM_CU; i++) begin
      rnd = {1'b0, cu_sums[i]} + ((CU_W + 1)'(1) << (FRAC_BITS - 1));
      shr = rnd >> FRAC_BITS;
      cube_r[i] = (shr > (CU_W + 1)'(CUOUT_ONES)) ? CUOUT_ONES : shr[CUOUT_W-1:0];
    end
  end

  // one shared root unit walks the six squared sums in turn
  afd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_go),
    .value (sq_sums[idx]),
    .done  (root_done),
    .root  (root_val)
  );

  // sequencer: accumulate, drain the lanes, take roots, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACC;
      cnt     <= '0;
      idx     <= '0;
      root_go <= 1'b0;
    end else begin
      root_go <= 1'b0;
      unique case (state)
        ST_ACC: begin
          if (accept) begin
            cnt <= last_eff ? '0 : cnt_inc;
            if (last_eff) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!(|lane_busy)) begin
            state   <= ST_ROOT;
            idx     <= '0;
            root_go <= 1'b1;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            if (idx == 3'(NUM_SQ - 1)) begin
              state <= ST_OUT;
            end else begin
              idx     <= idx + 1'b1;
              root_go <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

  // result registers, held steady through the output transfer
  always_ff @(posedge clk) begin
    if ((state == ST_ROOT) && root_done) begin
      dist_q[idx] <= root_val;
    end
    if ((state == ST_DRAIN) && !(|lane_busy)) begin
      for (int i = 0; i < NUM_CU; i++) begin
        cube_q[i] <= cube_r[i];
      end
    end
  end

  assign dist_user_a = dist_q[0];
  assign dist_user_b = dist_q[1];
  assign dist_user_c = dist_q[2];
  assign dist_a_b    = dist_q[3];
  assign dist_a_c    = dist_q[4];
  assign dist_b_c    = dist_q[5];
  assign cube_sum_a  = cube_q[0];
  assign cube_sum_b  = cube_q[1];
  assign cube_sum_c  = cube_q[2];

endmodule

// ===== sv/afd_lane.sv =====
`timescale 1ns / 1ps
// one difference lane: absolute difference, square, optional cube, saturating sums
module afd_lane #(
  parameter int DW       = 17,
  parameter bit HAS_CUBE = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  afd_pkg::lane_ctl_t       ctl,
  input  logic [DW-1:0]            x,
  input  logic [DW-1:0]            y,
  output logic                     busy,
  output logic [afd_pkg::SQ_W-1:0] sq_sum,
  output logic [afd_pkg::CU_W-1:0] cu_sum
);
  import afd_pkg::*;

  localparam int PW  = 2 * DW;
  localparam int CW  = 3 * DW;
  localparam int SSW = ((PW > SQ_W) ? PW : SQ_W) + 1;
  localparam int CSW = ((CW > CU_W) ? CW : CU_W) + 1;
  localparam logic [SQ_W-1:0] SQ_ONES = '1;
  localparam logic [CU_W-1:0] CU_ONES = '1;

  logic [2:0]    vld;
  logic [DW-1:0] d1;
  logic [DW-1:0] d2;
  logic [PW-1:0] p2;
  logic [PW-1:0] p3;
  logic [SSW-1:0] sq_add;

  assign busy = |vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    d1 <= (x > y) ? (x - y) : (y - x);
    d2 <= d1;
    p2 <= PW'(d1) * PW'(d1);
    p3 <= p2;
  end

  assign sq_add = SSW'(sq_sum) + SSW'(p3);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sq_sum <= '0;
    end else if (vld[2]) begin
      sq_sum <= (sq_add > SSW'(SQ_ONES)) ? SQ_ONES : sq_add[SQ_W-1:0];
    end
  end

  generate
    if (HAS_CUBE) begin : g_cube
      logic [CW-1:0]  c3;
      logic [CSW-1:0] cu_add;
      always_ff @(posedge clk) begin
        c3 <= CW'(p2) * CW'(d2);
      end
      assign cu_add = CSW'(cu_sum) + CSW'(c3);
      always_ff @(posedge clk) begin
        if (rst || ctl.clear) begin
          cu_sum <= '0;
        end else if (vld[2]) begin
          cu_sum <= (cu_add > CSW'(CU_ONES)) ? CU_ONES : cu_add[CU_W-1:0];
        end
      end
    end else begin : g_nocube
      assign cu_sum = '0;
    end
  endgenerate

endmodule

// ===== sv/afd_sqrt.sv =====
`timescale 1ns / 1ps
// digit-by-digit square root, one result bit a cycle, rounded to nearest
module afd_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [afd_pkg::SQ_W-1:0]   value,
  output logic                       done,
  output logic [afd_pkg::DIST_W-1:0] root
);
  import afd_pkg::*;

  localparam int RW = DIST_W + 3;
  localparam int SW = $clog2(DIST_W);
  localparam logic [DIST_W-1:0] ROOT_ONES = '1;

  logic            busy;
  logic            fin;
  logic [SW-1:0]   step;
  logic [SQ_W-1:0] rad;
  logic [RW-1:0]   rem;
  logic [DIST_W-1:0] q;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;
  logic            ge;

  assign rem_sh = {rem[RW-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = RW'({q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= value;
      rem  <= '0;
      q    <= '0;
      step <= SW'(DIST_W - 1);
    end else if (busy) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      step <= step - 1'b1;
      if (ge) begin
        rem <= rem_sh - trial;
        q   <= {q[DIST_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[DIST_W-2:0], 1'b0};
      end
    end
    if (fin) begin
      // round up when the remainder passes the root, hold at full scale
      root <= ((rem > RW'(q)) && (q != ROOT_ONES)) ? q + 1'b1 : q;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the allele frequency distance unit: directed table, random sets
module tb_top;
  import afd_pkg::*;

  localparam int SET_LIMIT  = MAX_SNPS_DEF;
  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int IDLE_PCT   = 38;
  localparam int RANDOM_CNT = 1650;
  localparam int DRAIN_CYC  = 160;     // covers the lane drain and the root sequence from closing snp to result
  localparam int STUCK_MAX  = 3000;    // cycles with no transfer on either side
  localparam int CALM_LO    = 4000;    // cycle window with no idling on either side
  localparam int CALM_HI    = 9000;

  localparam logic [63:0] SQ_SAT    = (64'd1 << SQ_W) - 1;
  localparam logic [63:0] CU_SAT    = (64'd1 << CU_W) - 1;
  localparam logic [63:0] DIST_SAT  = (64'd1 << DIST_W) - 1;
  localparam logic [63:0] CUOUT_SAT = (64'd1 << CUOUT_W) - 1;

  typedef struct {
    logic [FREQ_W-1:0] fa;
    logic [FREQ_W-1:0] fb;
    logic [FREQ_W-1:0] fc;
    logic [USER_W-1:0] user;
    logic              last;
  } snp_t;

  typedef struct {
    logic [DIST_W-1:0]  d_ua;
    logic [DIST_W-1:0]  d_ub;
    logic [DIST_W-1:0]  d_uc;
    logic [CUOUT_W-1:0] c_a;
    logic [CUOUT_W-1:0] c_b;
    logic [CUOUT_W-1:0] c_c;
    logic [DIST_W-1:0]  d_ab;
    logic [DIST_W-1:0]  d_ac;
    logic [DIST_W-1:0]  d_bc;
  } dist_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FREQ_W-1:0] freq_a = '0, freq_b = '0, freq_c = '0;
  logic [USER_W-1:0] user_derived = '0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0]  dist_user_a, dist_user_b, dist_user_c, dist_a_b, dist_a_c, dist_b_c;
  logic [CUOUT_W-1:0] cube_sum_a, cube_sum_b, cube_sum_c;

  allele_frequency_distance_unit dut (.*);

  always #5 clk = ~clk;

  // snp stream to send, plus an optional typed-in result per closing snp
  snp_t      snp_list[$];
  bit        typed_flag[$];
  dist_set_t typed_set[$];

  dist_set_t expected_sets[$];
  int        fail_cnt = 0;
  int        sent_cnt = 0;
  int        sets_seen = 0;
  int        cyc = 0;

  // running sums of the predictor
  logic [63:0] sq_acc[NUM_SQ];
  logic [63:0] cu_acc[NUM_CU];
  int          snps_in_set;

  function automatic logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] add,
                                          logic [63:0] lim);
    return (acc + add >= lim) ? lim : acc + add;
  endfunction

  // square root rounded to nearest, clipped to the distance width
  function automatic logic [DIST_W-1:0] root_round(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r++;
    if (r > DIST_SAT) r = DIST_SAT;
    return r[DIST_W-1:0];
  endfunction

  function automatic logic [CUOUT_W-1:0] cube_round(logic [63:0] s);
    logic [63:0] r;
    r = (s + (64'd1 << (FRAC - 1))) >> FRAC;
    if (r > CUOUT_SAT) r = CUOUT_SAT;
    return r[CUOUT_W-1:0];
  endfunction

  function automatic logic [63:0] gap(logic [63:0] x, logic [63:0] y);
    return x > y ? x - y : y - x;
  endfunction

  // adds one snp to the sums; returns 1 and the distances when the set closes
  function automatic bit accumulate_snp(snp_t s, output dist_set_t r);
    logic [63:0] fu;
    logic [63:0] d[NUM_SQ];
    bit          close;
    fu   = 64'(s.user) << (FRAC - 1);
    d[0] = gap(fu, s.fa);
    d[1] = gap(fu, s.fb);
    d[2] = gap(fu, s.fc);
    d[3] = gap(s.fa, s.fb);
    d[4] = gap(s.fa, s.fc);
    d[5] = gap(s.fb, s.fc);
    for (int i = 0; i < NUM_SQ; i++) sq_acc[i] = sat_sum(sq_acc[i], d[i] * d[i], SQ_SAT);
    for (int i = 0; i < NUM_CU; i++)
      cu_acc[i] = sat_sum(cu_acc[i], d[i] * d[i] * d[i], CU_SAT);
    snps_in_set++;
    // a set that runs too long closes by itself
    close = s.last || snps_in_set >= SET_LIMIT;
    r = '{root_round(sq_acc[0]), root_round(sq_acc[1]), root_round(sq_acc[2]),
          cube_round(cu_acc[0]), cube_round(cu_acc[1]), cube_round(cu_acc[2]),
          root_round(sq_acc[3]), root_round(sq_acc[4]), root_round(sq_acc[5])};
    if (close) begin
      foreach (sq_acc[i]) sq_acc[i] = 0;
      foreach (cu_acc[i]) cu_acc[i] = 0;
      snps_in_set = 0;
    end
    return close;
  endfunction

  function automatic void add_row(snp_t s, int reps, bit typed, dist_set_t r);
    for (int i = 0; i < reps; i++) begin
      snp_list.push_back(s);
      typed_flag.push_back(typed && i == reps - 1);
      typed_set.push_back(r);
    end
  endfunction

  function automatic logic [FREQ_W-1:0] rand_freq();
    // mostly legal frequencies, sometimes any 17-bit value
    if ($urandom_range(99) < 80) return FREQ_W'($urandom_range(65536));
    return FREQ_W'($urandom_range((1 << FREQ_W) - 1));
  endfunction

  function automatic bit calm();
    return cyc >= CALM_LO && cyc < CALM_HI;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // stimulus: directed table first, random sets after
  initial begin
    dist_set_t z;
    snp_t      s;
    int        len;
    z = '{default: '0};
    // empty-difference single-snp sets
    add_row('{0, 0, 0, 0, 1}, 1, 1, z);
    add_row('{65536, 65536, 65536, 2, 1}, 1, 1, z);
    // one population at 1.0 against a user with no derived allele
    add_row('{65536, 0, 0, 0, 1}, 1, 1,
            '{19'd65536, 0, 0, 38'd1 << 32, 0, 0, 19'd65536, 19'd65536, 0});
    // user count of three, read as frequency 1.5
    add_row('{0, 0, 0, 3, 1}, 1, 1,
            '{19'd98304, 19'd98304, 19'd98304,
              38'd14495514624, 38'd14495514624, 38'd14495514624, 0, 0, 0});
    // frequencies above one, mixed
    add_row('{131071, 131071, 131071, 0, 1}, 1, 0, z);
    add_row('{131071, 0, 65535, 3, 1}, 1, 0, z);
    add_row('{1, 65535, 32768, 1, 1}, 1, 0, z);
    // three-snp set
    add_row('{12000, 40000, 65536, 1, 0}, 1, 0, z);
    add_row('{50000, 100, 7000, 2, 0}, 1, 0, z);
    add_row('{65536, 30000, 0, 0, 1}, 1, 0, z);
    // set too long with saturating sums: closes by itself at the limit
    add_row('{131071, 131071, 131071, 0, 0}, SET_LIMIT, 1,
            '{DIST_W'(DIST_SAT), DIST_W'(DIST_SAT), DIST_W'(DIST_SAT),
              CUOUT_W'(CUOUT_SAT), CUOUT_W'(CUOUT_SAT), CUOUT_W'(CUOUT_SAT), 0, 0, 0});
    add_row('{200, 300, 400, 2, 1}, 1, 0, z);

    // random sets: mostly short, some single, some past the length limit
    while (snp_list.size() < RANDOM_CNT + 44) begin
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = $urandom_range(SET_LIMIT - 2, SET_LIMIT + 8);
        default: len = $urandom_range(2, 12);
      endcase
      for (int i = 0; i < len; i++) begin
        s.fa   = rand_freq();
        s.fb   = rand_freq();
        s.fc   = rand_freq();
        s.user = ($urandom_range(99) < 90) ? USER_W'($urandom_range(2)) : 2'd3;
        // closing flag on the last snp, rare noise flags elsewhere
        s.last = (i == len - 1) || ($urandom_range(99) < 2);
        add_row(s, 1, 0, z);
      end
    end
  end

  // input side: hold a stalled transfer, otherwise idle at random or present the next snp
  always @(posedge clk) begin
    dist_set_t r;
    bit        fire;
    cyc <= cyc + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fire = accumulate_snp(snp_list[sent_cnt], r);
        if (fire) expected_sets.push_back(typed_flag[sent_cnt] ? typed_set[sent_cnt] : r);
        sent_cnt = sent_cnt + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (sent_cnt < snp_list.size() && (calm() || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid     <= 1'b1;
          freq_a       <= snp_list[sent_cnt].fa;
          freq_b       <= snp_list[sent_cnt].fb;
          freq_c       <= snp_list[sent_cnt].fc;
          user_derived <= snp_list[sent_cnt].user;
          last_item    <= snp_list[sent_cnt].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure and comparison against the oldest expected set
  always @(posedge clk) begin
    dist_set_t e;
    out_stall <= !rst && !calm() && ($urandom_range(99) < IDLE_PCT);
    if (!rst && out_valid && !out_stall) begin
      sets_seen++;
      if (expected_sets.size() == 0) begin
        $error("result transfer with no expected set");
        fail_cnt++;
      end else begin
        e = expected_sets.pop_front();
        check_field("dist_user_a", e.d_ua, dist_user_a);
        check_field("dist_user_b", e.d_ub, dist_user_b);
        check_field("dist_user_c", e.d_uc, dist_user_c);
        check_field("cube_sum_a", e.c_a, cube_sum_a);
        check_field("cube_sum_b", e.c_b, cube_sum_b);
        check_field("cube_sum_c", e.c_c, cube_sum_c);
        check_field("dist_a_b", e.d_ab, dist_a_b);
        check_field("dist_a_c", e.d_ac, dist_a_c);
        check_field("dist_b_c", e.d_bc, dist_b_c);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  int stuck = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_MAX) begin
      $display("timeout after %0d idle cycles", stuck);
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    foreach (sq_acc[i]) sq_acc[i] = 0;
    foreach (cu_acc[i]) cu_acc[i] = 0;
    snps_in_set = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // wait for the stimulus to fill in before testing its size
    @(posedge clk);
    wait (sent_cnt == snp_list.size());
    wait (expected_sets.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("sent %0d snps, checked %0d distance sets", sent_cnt, sets_seen);
    $display("covered single, multi-snp and over-long sets, saturation, user count of three");
    if (fail_cnt == 0 && expected_sets.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
